// ===== rtl/core/dqs_pkg.sv =====
// Shared constants and types for the searchable double-ended queue.
// Used by dqs_cell, the top level and the port checker.
`timescale 1ns / 1ps
package dqs_pkg;

  localparam int DEPTH   = 16;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int WORD_W  = 32;
  localparam int MODE_W  = 2;
  localparam int FILL_W  = 5;
  localparam int FPOS_W  = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;

  localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POP_BACK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 2'd3;

  // bit positions in out_tdata
  localparam int OUT_FILL_LSB  = 32;
  localparam int OUT_FOUND_BIT = 37;
  localparam int OUT_FPOS_LSB  = 38;
  localparam int OUT_EMPTY_BIT = 42;
  localparam int OUT_DROP_BIT  = 43;

  typedef struct packed {
    logic load;
    logic shift;
    logic cmp_en;
    logic live;
  } dqs_cell_ctl_t;

endpackage

// ===== rtl/core/double_ended_queue_with_search_top.sv =====
// Top level of the searchable double-ended queue: a chain of dqs_cell storage
// cells with fill counter, a result staging register and the output register.
// Depends on dqs_pkg and dqs_cell.
//
//   channel | ports          | word contents (lowest bit first)
//   --------+----------------+----------------------------------------------------
//   input   | in_t*          | tuser: mode[1:0]; tdata: value[31:0]
//   result  | out_t*         | tdata: read_value[31:0], fill_after[36:32], found[37],
//           |                |        found_position[41:38], empty_error[42],
//           |                |        full_drop[43], zero[47:44]
//
// One word per cycle sustained while results are taken. Acceptance updates the cell
// chain, latches every cell's compare and loads the staging register; advance then
// priority-encodes the first match and loads the output register.
// Reset clears the fill count and the valid flags; cell contents stay undefined.
// A stalled result holds the output; input stalls once the staging register is also full.
`timescale 1ns / 1ps
module double_ended_queue_with_search_top import dqs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [MODE_W-1:0]      in_tuser,   // mode[1:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // read_value, fill_after, found,
                                             // found_position, empty_error, full_drop
);

  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              pend_r, pend_nxt;
  logic [MODE_W-1:0] pend_mode_r;
  logic [WORD_W-1:0] pend_read_r;
  logic [CNT_W-1:0]  pend_fill_r;
  logic              pend_empty_r, pend_drop_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [WORD_W-1:0] cell_word  [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  dqs_cell_ctl_t     cell_ctl   [DEPTH];

  logic              accept, out_free, advance;
  logic              is_push, is_pop_f, is_pop_b;
  logic              empty, full;
  logic [IDX_W-1:0]  back_idx;
  logic [WORD_W-1:0] pop_word;
  logic [IDX_W-1:0]  hit_idx;
  logic              hit_any;
  logic [WORD_W-1:0] value;

  assign value    = in_tdata[WORD_W-1:0];
  assign out_free = !out_valid_r || out_tready;
  assign advance  = pend_r && out_free;
  assign in_tready = !pend_r || out_free;
  assign accept   = in_tvalid && in_tready;

  assign is_push  = in_tuser == MODE_PUSH_BACK;
  assign is_pop_f = in_tuser == MODE_POP_FRONT;
  assign is_pop_b = in_tuser == MODE_POP_BACK;
  assign empty    = fill_r == '0;
  assign full     = fill_r == CNT_W'(DEPTH);
  assign back_idx = IDX_W'(fill_r - CNT_W'(1));

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic [WORD_W-1:0] nbr;
      if (g == DEPTH - 1) begin : g_last
        assign nbr = '0;
      end else begin : g_mid
        assign nbr = cell_word[g+1];
      end

      assign cell_ctl[g].load   = accept && is_push && !full &&
                                  (fill_r[IDX_W-1:0] == IDX_W'(g));
      assign cell_ctl[g].shift  = accept && is_pop_f && !empty;
      assign cell_ctl[g].cmp_en = accept;
      assign cell_ctl[g].live   = fill_r > CNT_W'(g);

      dqs_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[g]),
        .push_word (value),
        .next_word (nbr),
        .key       (value),
        .word      (cell_word[g]),
        .match     (cell_match[g])
      );
    end
  endgenerate

  always_comb begin
    fill_nxt = fill_r;
    pop_word = '0;
    if (accept) begin
      if (is_push && !full) begin
        fill_nxt = fill_r + CNT_W'(1);
      end else if ((is_pop_f || is_pop_b) && !empty) begin
        fill_nxt = fill_r - CNT_W'(1);
        pop_word = is_pop_f ? cell_word[0] : cell_word[back_idx];
      end
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (accept) begin
      pend_nxt = 1'b1;
    end else if (advance) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    hit_any = (|cell_match) && (pend_mode_r == MODE_SEARCH);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_mode_r  <= in_tuser;
      pend_read_r  <= pop_word;
      pend_fill_r  <= fill_nxt;
      pend_empty_r <= (is_pop_f || is_pop_b) && empty;
      pend_drop_r  <= is_push && full;
    end
    if (advance) begin
      out_data_r <= {4'b0,
                     pend_drop_r,
                     pend_empty_r,
                     hit_any ? FPOS_W'(hit_idx) : FPOS_W'(0),
                     hit_any,
                     FILL_W'(pend_fill_r),
                     pend_read_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/dqs_cell.sv =====
// One storage cell of the queue chain: holds one word, takes its neighbor's word
// on a front pop, loads a pushed word and flags a match against the search key.
// Depends on dqs_pkg.
`timescale 1ns / 1ps
module dqs_cell import dqs_pkg::*; (
  input  logic              clk,
  input  dqs_cell_ctl_t     ctl,
  input  logic [WORD_W-1:0] push_word,
  input  logic [WORD_W-1:0] next_word,
  input  logic [WORD_W-1:0] key,
  output logic [WORD_W-1:0] word,
  output logic              match
);

  logic [WORD_W-1:0] word_r, word_nxt;
  logic              match_r, match_nxt;

  always_comb begin
    word_nxt = word_r;
    if (ctl.load) begin
      word_nxt = push_word;
    end else if (ctl.shift) begin
      word_nxt = next_word;
    end
  end

  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = ctl.live && (word_r == key);
    end
  end

  always_ff @(posedge clk) begin
    word_r  <= word_nxt;
    match_r <= match_nxt;
  end

  assign word  = word_r;
  assign match = match_r;

endmodule

// ===== rtl/core/dqs_port_check.sv =====
// Port-level checker for the searchable double-ended queue, bound to the top level.
// Depends on dqs_pkg and double_ended_queue_with_search_top.
`timescale 1ns / 1ps
module dqs_port_check import dqs_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [FILL_W-1:0] fill;
  logic [FPOS_W-1:0] fpos;
  logic              found, empty_err, drop;

  assign fill      = out_tdata[OUT_FILL_LSB +: FILL_W];
  assign fpos      = out_tdata[OUT_FPOS_LSB +: FPOS_W];
  assign found     = out_tdata[OUT_FOUND_BIT];
  assign empty_err = out_tdata[OUT_EMPTY_BIT];
  assign drop      = out_tdata[OUT_DROP_BIT];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(empty_err && drop) && !(found && (empty_err || drop)))
    else $error("conflicting result flags");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && empty_err |-> fill == '0 && out_tdata[WORD_W-1:0] == '0)
    else $error("empty pop with data or nonzero fill");

  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && found |-> FILL_W'(fpos) < fill)
    else $error("match position beyond fill level");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && drop |-> fill == FILL_W'(DEPTH))
    else $error("push dropped while not full");

endmodule

bind double_ended_queue_with_search_top dqs_port_check u_dqs_port_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
